>>> design/dq_pkg.sv
// Shared constants, opcodes, status codes and control structs for the deque.
// Has no dependencies; dq_ptr and double_ended_queue import it.
package dq_pkg;

  localparam int DEPTH  = 1024;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;

  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_SIZE       = 3'd4;
  localparam logic [2:0] OP_EMPTY      = 3'd5;
  localparam logic [2:0] OP_FRONT      = 3'd6;
  localparam logic [2:0] OP_BACK       = 3'd7;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic                     valid;
    logic signed [DATA_W-1:0] value;
    logic [1:0]               status;
  } imm_res_t;

endpackage

>>> design/dq_ram.sv
// Generic single-write, single-read synchronous RAM, registered read data.
// No package dependencies.
module dq_ram #(
  parameter int DEPTH  = 1024,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/dq_ptr.sv
// Head pointer and entry count of the deque: address generation for the store
// and results that need no store read. Depends on dq_pkg.
module dq_ptr (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    accept,
  input  logic [2:0]              opcode,
  output dq_pkg::mem_req_t        req,
  output dq_pkg::imm_res_t        imm,
  output logic [dq_pkg::CNT_W-1:0] count
);
  import dq_pkg::*;

  logic [ADDR_W-1:0] head, head_next, head_dec, head_inc;
  logic [CNT_W-1:0]  count_next;
  logic [CNT_W:0]    sum_wr, sum_rd;
  logic [ADDR_W-1:0] back_wr, back_rd;
  logic              empty, full;

  assign empty   = (count == '0);
  assign full    = (count == CNT_W'(DEPTH));

  assign head_dec = (head == '0) ? ADDR_W'(DEPTH - 1) : head - 1'b1;
  assign head_inc = (head == ADDR_W'(DEPTH - 1)) ? '0 : head + 1'b1;

  assign sum_wr  = (CNT_W+1)'(head) + (CNT_W+1)'(count);
  assign sum_rd  = sum_wr - 1'b1;
  assign back_wr = (sum_wr >= (CNT_W+1)'(DEPTH)) ? ADDR_W'(sum_wr - (CNT_W+1)'(DEPTH))
                                                  : ADDR_W'(sum_wr);
  assign back_rd = (sum_rd >= (CNT_W+1)'(DEPTH)) ? ADDR_W'(sum_rd - (CNT_W+1)'(DEPTH))
                                                  : ADDR_W'(sum_rd);

  always_comb begin
    head_next  = head;
    count_next = count;
    req        = '0;
    imm        = '0;
    case (opcode)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (full) begin
          imm = '{valid: 1'b1, value: '0, status: ST_FULL};
        end else begin
          req.we     = 1'b1;
          count_next = count + 1'b1;
          if (opcode == OP_PUSH_FRONT) begin
            req.waddr = head_dec;
            head_next = head_dec;
          end else begin
            req.waddr = back_wr;
          end
        end
      end
      OP_SIZE: begin
        imm = '{valid: 1'b1, value: DATA_W'(count), status: ST_OK};
      end
      OP_EMPTY: begin
        imm = '{valid: 1'b1, value: DATA_W'(empty), status: ST_OK};
      end
      default: begin
        if (empty) begin
          imm = '{valid: 1'b1, value: '1, status: ST_EMPTY};
        end else begin
          req.re = 1'b1;
          if (opcode == OP_POP_FRONT || opcode == OP_FRONT) begin
            req.raddr = head;
          end else begin
            req.raddr = back_rd;
          end
          if (opcode == OP_POP_FRONT) begin
            head_next  = head_inc;
            count_next = count - 1'b1;
          end else if (opcode == OP_POP_BACK) begin
            count_next = count - 1'b1;
          end
        end
      end
    endcase
    if (!accept) begin
      head_next  = head;
      count_next = count;
      req        = '0;
      imm        = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      count <= count_next;
    end
  end

endmodule

>>> design/double_ended_queue.sv
// Double-ended queue of signed 32-bit words, top level.
// Depends on dq_pkg, dq_ptr and dq_ram.
//
// Usage:
//   Input channel (in_valid/in_ready) carries opcode and push_value. Output
//   channel (out_valid/out_ready) carries result_value and status.
//   Pushes produce no output transaction unless the queue is full (status 2).
//   Size, empty, and any pop/peek on an empty queue produce their result in the
//   cycle after acceptance, straight from the pointer logic.
//   Pops and peeks on a non-empty queue read the entry store, a synchronous
//   RAM with registered read data, so their result passes through the RAM read
//   register and then the output register.
//   Throughput: one transaction per cycle for pushes, size and empty while
//   the receiver keeps up; a store read blocks input until it is registered.
//   The output register holds one result; a new transaction is accepted while
//   it is being taken, so a stalled receiver stalls the input after one
//   result waits.
//   Reset clears the head pointer, the entry count and the output valid; the
//   store contents are undefined until written and need no clearing pass.
module double_ended_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          opcode,
  input  logic signed [31:0]  push_value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  result_value,
  output logic [1:0]          status
);
  import dq_pkg::*;

  mem_req_t           req;
  imm_res_t           imm;
  logic [CNT_W-1:0]   count;
  logic [DATA_W-1:0]  rdata;
  logic               accept;
  logic               pend;

  assign in_ready = !pend && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  dq_ptr u_ptr (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .opcode (opcode),
    .req    (req),
    .imm    (imm),
    .count  (count)
  );

  dq_ram #(
    .DEPTH (DEPTH),
    .WIDTH (DATA_W)
  ) u_ram (
    .clk   (clk),
    .we    (req.we),
    .waddr (req.waddr),
    .wdata (push_value),
    .re    (req.re),
    .raddr (req.raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      pend <= req.re;
      if (pend || imm.valid) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pend) begin
      result_value <= rdata;
      status       <= ST_OK;
    end else if (imm.valid) begin
      result_value <= imm.value;
      status       <= imm.status;
    end
  end

`ifndef SYNTHESIS
  a_read_returns: assert property (@(posedge clk) disable iff (rst) pend |=> out_valid)
    else $error("store read did not produce a result");
  a_slot_free: assert property (@(posedge clk) disable iff (rst) pend |-> !out_valid)
    else $error("store read result would overwrite a waiting result");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count exceeds depth");
  a_no_overlap: assert property (@(posedge clk) disable iff (rst) !(req.we && req.re))
    else $error("write and read issued for one transaction");
`endif

endmodule
